>>> rtl/dsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diamond-square heightmap package
// Shared types, register indexes, reset values and the default grid size.
// ----------------------------------------------------------------------------
package dsh_pkg;

	localparam int LOG2_GRID_SIZE_DEF = 6;

	localparam logic [15:0] INITIAL_RANGE_RST = 16'd256;
	localparam logic [15:0] DECAY_FACTOR_RST  = 16'd45875;
	localparam logic [3:0]  REFINE_PASSES_RST = 4'd5;

	typedef enum logic [1:0] {
		REG_INITIAL_RANGE = 2'd0,
		REG_DECAY_FACTOR  = 2'd1,
		REG_REFINE_PASSES = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_SEED     = 2'd0,
		PH_DIAMOND  = 2'd1,
		PH_SIDE_ROW = 2'd2,
		PH_SIDE_COL = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_READ  = 2'd1,
		ST_WRITE = 2'd2
	} st_t;

	typedef struct packed {
		logic signed [15:0] noise_sample;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         point_x;
		logic [5:0]         point_y;
		logic signed [31:0] height;
		logic               last_point;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  reg_index;
		logic [15:0] wr_data;
	} cfg_item_t;

endpackage

>>> rtl/dsh_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload per transfer between a source and a sink.
// ----------------------------------------------------------------------------
interface dsh_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/dsh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module dsh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/diamond_square_heightmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diamond-square heightmap generator
// Places one noise sample per transfer on a wrapping square grid and returns
// the coordinates and saturated height of each new point.
// ----------------------------------------------------------------------------
// channel | dir | payload                                   | transfer when
// sample  | in  | noise_sample                              | valid & ready
// point   | out | point_x, point_y, height, last_point      | valid & ready
// cfg     | in  | reg_index, wr_data                        | valid & ready
//
// A seed point takes the sample from the input buffer and is written; a refined
// point takes the sample from the input buffer, makes four neighbor reads on the
// single grid RAM port, adds in the last read data and is written.
// The sample channel is ready while the input buffer is empty or hands its
// sample to the idle core, so the next sample waits while a point is computed.
// A stalled result holds the core in its write cycle; at most three samples
// are in flight. Reset clears the sequencer and the registers, not the grid RAM.
// ----------------------------------------------------------------------------
module diamond_square_heightmap #(
	parameter int LOG2_GRID_SIZE = dsh_pkg::LOG2_GRID_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dsh_stream_if.sink    sample,
	dsh_stream_if.source  point,
	dsh_stream_if.sink    cfg
);

	localparam int L  = LOG2_GRID_SIZE;
	localparam int AW = 2 * L;
	localparam logic [3:0] L_LIMIT = 4'(L);
	localparam logic [L:0] SPACING_RST = (L + 1)'(1 << (L - 1));

	dsh_pkg::st_t st_q, st_nxt;
	dsh_pkg::phase_t phase_q, phase_nxt;

	logic [15:0] init_range_q, decay_q;
	logic [3:0]  passes_q;

	logic [L-1:0] cur_x_q, cur_y_q, x_nxt, y_nxt;
	logic [L:0]   spacing_q, spacing_nxt;
	logic [3:0]   levels_q, levels_nxt;
	logic [15:0]  range_q, range_nxt;
	logic [2:0]   rd_cnt_q;

	logic               buf_valid_q;
	logic signed [15:0] buf_noise_q;

	logic signed [32:0] prod_s1;
	logic signed [33:0] sum_s1;

	logic                out_valid_q;
	dsh_pkg::out_item_t  out_q;

	logic core_take, out_free, wr_fire, last_nxt;
	logic [15:0] rng_sel;
	logic [L-1:0] h_w, xm, xp, ym, yp, nbr_x, nbr_y;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [31:0] mem_rdata, height_val;
	logic signed [33:0] mean;
	logic signed [32:0] noise_term;
	logic signed [34:0] val_wide;
	logic [31:0] decay_prod;
	logic [3:0] limit;

	dsh_ram #(
		.WIDTH(32),
		.DEPTH(1 << AW)
	) u_grid (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(height_val),
		.rdata(mem_rdata)
	);

	assign out_free  = !out_valid_q || point.ready;
	assign core_take = (st_q == dsh_pkg::ST_IDLE) && buf_valid_q;
	assign wr_fire   = (st_q == dsh_pkg::ST_WRITE) && out_free;

	assign sample.ready = !buf_valid_q || core_take;
	assign cfg.ready    = 1'b1;
	assign point.valid  = out_valid_q;
	assign point.data   = out_q;

	assign rng_sel = (phase_q == dsh_pkg::PH_SEED && cur_x_q == '0 && cur_y_q == '0) ?
		init_range_q : range_q;

	assign h_w = spacing_q[L:1];
	assign xm  = cur_x_q - h_w;
	assign xp  = cur_x_q + h_w;
	assign ym  = cur_y_q - h_w;
	assign yp  = cur_y_q + h_w;

	always_comb begin
		nbr_x = cur_x_q;
		nbr_y = cur_y_q;
		if (phase_q == dsh_pkg::PH_DIAMOND) begin
			nbr_x = rd_cnt_q[0] ? xp : xm;
			nbr_y = rd_cnt_q[1] ? yp : ym;
		end else begin
			unique case (rd_cnt_q[1:0])
				2'd0: nbr_x = xm;
				2'd1: nbr_x = xp;
				2'd2: nbr_y = ym;
				2'd3: nbr_y = yp;
				default: nbr_x = cur_x_q;
			endcase
		end
	end

	assign mean       = sum_s1 >>> 2;
	assign noise_term = prod_s1 >>> 8;
	assign val_wide   = {mean[33], mean} + {{2{noise_term[32]}}, noise_term};

	always_comb begin
		if (val_wide[34:31] == 4'b0000 || val_wide[34:31] == 4'b1111) begin
			height_val = val_wide[31:0];
		end else if (val_wide[34]) begin
			height_val = 32'h8000_0000;
		end else begin
			height_val = 32'h7FFF_FFFF;
		end
	end

	// Grid RAM port and state transitions.
	always_comb begin
		mem_we   = 1'b0;
		mem_addr = {cur_y_q, cur_x_q};
		if (st_q == dsh_pkg::ST_READ) begin
			mem_addr = {nbr_y, nbr_x};
		end else if (wr_fire) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			dsh_pkg::ST_IDLE: begin
				if (buf_valid_q) begin
					st_nxt = (phase_q == dsh_pkg::PH_SEED) ? dsh_pkg::ST_WRITE :
						dsh_pkg::ST_READ;
				end
			end
			dsh_pkg::ST_READ: begin
				if (rd_cnt_q == 3'd4) begin
					st_nxt = dsh_pkg::ST_WRITE;
				end
			end
			dsh_pkg::ST_WRITE: begin
				if (out_free) begin
					st_nxt = dsh_pkg::ST_IDLE;
				end
			end
			default: st_nxt = dsh_pkg::ST_IDLE;
		endcase
	end

	assign limit      = (passes_q < L_LIMIT) ? passes_q : L_LIMIT;
	assign decay_prod = range_q * decay_q;

	// Sequencer step after a point is written.
	always_comb begin
		logic [L:0] nx, ny, sp_lvl;
		logic [L-1:0] h_new;
		logic [3:0] lv_lvl;
		logic begin_level;

		nx          = {1'b0, cur_x_q} + spacing_q;
		ny          = {1'b0, cur_y_q} + spacing_q;
		x_nxt       = nx[L-1:0];
		y_nxt       = cur_y_q;
		phase_nxt   = phase_q;
		spacing_nxt = spacing_q;
		levels_nxt  = levels_q;
		range_nxt   = range_q;
		last_nxt    = 1'b0;
		begin_level = 1'b0;
		sp_lvl      = spacing_q;
		lv_lvl      = levels_q;
		h_new       = h_w;

		if (nx[L]) begin
			x_nxt = (phase_q == dsh_pkg::PH_DIAMOND || phase_q == dsh_pkg::PH_SIDE_COL) ?
				h_w : '0;
			y_nxt = ny[L-1:0];
			if (ny[L]) begin
				unique case (phase_q)
					dsh_pkg::PH_SEED: begin
						begin_level = 1'b1;
					end
					dsh_pkg::PH_DIAMOND: begin
						phase_nxt = dsh_pkg::PH_SIDE_ROW;
						x_nxt     = '0;
						y_nxt     = h_w;
					end
					dsh_pkg::PH_SIDE_ROW: begin
						phase_nxt = dsh_pkg::PH_SIDE_COL;
						x_nxt     = h_w;
						y_nxt     = '0;
					end
					dsh_pkg::PH_SIDE_COL: begin
						sp_lvl      = spacing_q >> 1;
						lv_lvl      = levels_q + 4'd1;
						spacing_nxt = sp_lvl;
						levels_nxt  = lv_lvl;
						begin_level = 1'b1;
					end
					default: begin_level = 1'b0;
				endcase
				if (begin_level) begin
					h_new = sp_lvl[L:1];
					if (lv_lvl < limit && sp_lvl != '0) begin
						phase_nxt = dsh_pkg::PH_DIAMOND;
						range_nxt = decay_prod[31:16];
						x_nxt     = h_new;
						y_nxt     = h_new;
					end else begin
						last_nxt    = 1'b1;
						phase_nxt   = dsh_pkg::PH_SEED;
						spacing_nxt = SPACING_RST;
						levels_nxt  = '0;
						x_nxt       = '0;
						y_nxt       = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= dsh_pkg::ST_IDLE;
			phase_q      <= dsh_pkg::PH_SEED;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			spacing_q    <= SPACING_RST;
			levels_q     <= '0;
			range_q      <= dsh_pkg::INITIAL_RANGE_RST;
			rd_cnt_q     <= '0;
			buf_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			init_range_q <= dsh_pkg::INITIAL_RANGE_RST;
			decay_q      <= dsh_pkg::DECAY_FACTOR_RST;
			passes_q     <= dsh_pkg::REFINE_PASSES_RST;
		end else begin
			st_q <= st_nxt;
			if (cfg.valid) begin
				unique case (cfg.data.reg_index)
					dsh_pkg::REG_INITIAL_RANGE: init_range_q <= cfg.data.wr_data;
					dsh_pkg::REG_DECAY_FACTOR:  decay_q      <= cfg.data.wr_data;
					dsh_pkg::REG_REFINE_PASSES: passes_q     <= cfg.data.wr_data[3:0];
					default:                    passes_q     <= passes_q;
				endcase
			end
			if (sample.valid && sample.ready) begin
				buf_valid_q <= 1'b1;
			end else if (core_take) begin
				buf_valid_q <= 1'b0;
			end
			if (core_take) begin
				range_q  <= rng_sel;
				rd_cnt_q <= '0;
			end else if (st_q == dsh_pkg::ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
			end
			if (wr_fire) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_nxt;
				cur_x_q     <= x_nxt;
				cur_y_q     <= y_nxt;
				spacing_q   <= spacing_nxt;
				levels_q    <= levels_nxt;
				range_q     <= range_nxt;
			end else if (point.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			buf_noise_q <= sample.data.noise_sample;
		end
		if (core_take) begin
			prod_s1 <= buf_noise_q * $signed({1'b0, rng_sel});
			sum_s1  <= '0;
		end else if (st_q == dsh_pkg::ST_READ && rd_cnt_q != 3'd0) begin
			sum_s1 <= sum_s1 + {{2{mem_rdata[31]}}, mem_rdata};
		end
		if (wr_fire) begin
			out_q.point_x    <= 6'(cur_x_q);
			out_q.point_y    <= 6'(cur_y_q);
			out_q.height     <= height_val;
			out_q.last_point <= last_nxt;
		end
	end

endmodule

>>> rtl/dsh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diamond-square heightmap port checker
// Tracks items in flight from the port transfers and checks the sample and result sides.
// ----------------------------------------------------------------------------
module dsh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input dsh_pkg::out_item_t out_data
);

	logic [2:0] inflight_q;
	logic in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {2'b00, in_xfer} - {2'b00, out_xfer};
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result shown with no sample in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3)
		else $error("more samples in flight than the block can hold");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> in_ready)
		else $error("sample channel stalled while the block is empty");

endmodule

bind diamond_square_heightmap dsh_checker u_dsh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (sample.valid),
	.in_ready (sample.ready),
	.out_valid(point.valid),
	.out_ready(point.ready),
	.out_data (point.data)
);
